// ----- hdl/amrd_pkg.sv -----
// ----------------------------------------------------------------------------
// amrd_pkg - shared types and constants of the storage-file frame deframer
// Byte kinds, the file magic, the frame size table and the record that the
// front part hands to the back part through the queue.
// ----------------------------------------------------------------------------
package amrd_pkg;

	localparam int MAGIC_LEN   = 6;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 32;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_START_TIME = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_GROUP  = 1'd1;

	localparam logic [3:0] MAX_GROUP_RESET = 4'd10;

	typedef enum logic [1:0] {
		KIND_MAGIC   = 2'd0,
		KIND_HEADER  = 2'd1,
		KIND_PAYLOAD = 2'd2,
		KIND_ERROR   = 2'd3
	} kind_t;

	// One classified byte, as it travels from the front to the back.
	typedef struct packed {
		logic [7:0]  data_byte;
		kind_t       kind;
		logic [3:0]  frame_mode;
		logic [5:0]  frame_size;
		logic [31:0] frame_time;
		logic        skipped;
		logic        group_start;
		logic        last;
		logic [31:0] sample_clock;
	} rec_t;

	// Expected byte at each place of the file magic "#!AMR\n".
	function automatic logic [7:0] magic_byte(input logic [2:0] pos);
		logic [7:0] b;
		case (pos)
			3'd0:    b = 8'h23;
			3'd1:    b = 8'h21;
			3'd2:    b = 8'h41;
			3'd3:    b = 8'h4d;
			3'd4:    b = 8'h52;
			3'd5:    b = 8'h0a;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// Frame length in bytes, header byte included, for each mode.
	function automatic logic [5:0] frame_bytes(input logic [3:0] mode);
		logic [5:0] s;
		case (mode)
			4'd0:    s = 6'd13;
			4'd1:    s = 6'd14;
			4'd2:    s = 6'd16;
			4'd3:    s = 6'd18;
			4'd4:    s = 6'd20;
			4'd5:    s = 6'd21;
			4'd6:    s = 6'd27;
			4'd7:    s = 6'd32;
			4'd8:    s = 6'd6;
			default: s = 6'd1;
		endcase
		return s;
	endfunction

endpackage

// ----- hdl/amrd_front.sv -----
// ----------------------------------------------------------------------------
// amrd_front - byte classifier
// Checks the magic, tracks frame boundaries, the sample clock and grouping,
// and builds one record per accepted byte.
// ----------------------------------------------------------------------------
module amrd_front #(
	parameter int FRAME_SAMPLES = 160
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         data_byte,
	input  logic               last,
	input  logic [31:0]        start_time,
	input  logic [3:0]         max_group,
	output amrd_pkg::rec_t     rec
);
	import amrd_pkg::*;

	logic [2:0]  magic_pos_q,    magic_pos_d;
	logic        header_bad_q,   header_bad_d;
	logic [4:0]  bytes_left_q,   bytes_left_d;
	logic [3:0]  cur_mode_q,     cur_mode_d;
	logic [5:0]  cur_size_q,     cur_size_d;
	logic [31:0] sample_clock_q, sample_clock_d;
	logic [3:0]  group_frames_q, group_frames_d;
	logic [5:0]  group_size_q,   group_size_d;

	logic [3:0]  lim;
	logic [3:0]  hdr_mode;
	logic [5:0]  hdr_size;
	logic [31:0] ftime;
	logic [32:0] end_time;
	logic        skip;

	assign lim      = (max_group == 4'd0) ? 4'd1 : max_group;
	assign hdr_mode = data_byte[6:3];
	assign hdr_size = frame_bytes(hdr_mode);

	// A header byte opens a frame at the current clock; payload bytes belong to
	// the frame one step back.
	assign ftime    = (bytes_left_q == 5'd0) ? sample_clock_q
	                                         : sample_clock_q - 32'(FRAME_SAMPLES);
	assign end_time = {1'b0, ftime} + 33'(FRAME_SAMPLES);
	assign skip     = end_time < {1'b0, start_time};

	always_comb begin
		magic_pos_d    = magic_pos_q;
		header_bad_d   = header_bad_q;
		bytes_left_d   = bytes_left_q;
		cur_mode_d     = cur_mode_q;
		cur_size_d     = cur_size_q;
		sample_clock_d = sample_clock_q;
		group_frames_d = group_frames_q;
		group_size_d   = group_size_q;

		rec              = '0;
		rec.data_byte    = data_byte;
		rec.last         = last;
		rec.kind         = KIND_ERROR;

		if (header_bad_q) begin
			rec.kind = KIND_ERROR;
		end else if (magic_pos_q < 3'(MAGIC_LEN)) begin
			if (data_byte == magic_byte(magic_pos_q)) begin
				rec.kind    = KIND_MAGIC;
				magic_pos_d = magic_pos_q + 3'd1;
			end else begin
				rec.kind     = KIND_ERROR;
				header_bad_d = 1'b1;
			end
		end else if (bytes_left_q == 5'd0) begin
			cur_mode_d       = hdr_mode;
			cur_size_d       = hdr_size;
			bytes_left_d     = 5'(hdr_size - 6'd1);
			sample_clock_d   = sample_clock_q + 32'(FRAME_SAMPLES);
			rec.kind         = KIND_HEADER;
			rec.frame_mode   = hdr_mode;
			rec.frame_size   = hdr_size;
			rec.frame_time   = ftime;
			rec.skipped      = skip;
			if (skip) begin
				group_frames_d = 4'd0;
			end else if (group_frames_q == 4'd0 || group_size_q != hdr_size
			             || group_frames_q >= lim) begin
				rec.group_start = 1'b1;
				group_frames_d  = 4'd1;
				group_size_d    = hdr_size;
			end else begin
				group_frames_d = group_frames_q + 4'd1;
			end
		end else begin
			bytes_left_d   = bytes_left_q - 5'd1;
			rec.kind       = KIND_PAYLOAD;
			rec.frame_mode = cur_mode_q;
			rec.frame_size = cur_size_q;
			rec.frame_time = ftime;
			rec.skipped    = skip;
		end

		rec.sample_clock = sample_clock_d;

		// The end of a file returns the parser to its starting point.
		if (last) begin
			magic_pos_d    = '0;
			header_bad_d   = 1'b0;
			bytes_left_d   = '0;
			cur_mode_d     = '0;
			cur_size_d     = '0;
			sample_clock_d = '0;
			group_frames_d = '0;
			group_size_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_pos_q    <= '0;
			header_bad_q   <= 1'b0;
			bytes_left_q   <= '0;
			cur_mode_q     <= '0;
			cur_size_q     <= '0;
			sample_clock_q <= '0;
			group_frames_q <= '0;
			group_size_q   <= '0;
		end else if (accept) begin
			magic_pos_q    <= magic_pos_d;
			header_bad_q   <= header_bad_d;
			bytes_left_q   <= bytes_left_d;
			cur_mode_q     <= cur_mode_d;
			cur_size_q     <= cur_size_d;
			sample_clock_q <= sample_clock_d;
			group_frames_q <= group_frames_d;
			group_size_q   <= group_size_d;
		end
	end

endmodule

// ----- hdl/amrd_queue.sv -----
// ----------------------------------------------------------------------------
// amrd_queue - record queue between front and back
// A small first-in first-out store of classified records.
// ----------------------------------------------------------------------------
module amrd_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  amrd_pkg::rec_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output amrd_pkg::rec_t rd_data,
	output logic           not_empty
);
	import amrd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rec_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hdl/amrd_back.sv -----
// ----------------------------------------------------------------------------
// amrd_back - result stage
// Takes records from the queue, forms the result beat and holds it in the
// output register until it is popped.
// ----------------------------------------------------------------------------
module amrd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rec_valid,
	input  amrd_pkg::rec_t rec,
	output logic           rec_take,
	input  logic           pop,
	output logic           empty,
	output logic [7:0]     byte_out,
	output logic [1:0]     kind,
	output logic [3:0]     frame_mode,
	output logic [5:0]     frame_size,
	output logic [31:0]    frame_time,
	output logic           skipped,
	output logic           group_start,
	output logic           last_out,
	output logic [31:0]    total_duration
);
	import amrd_pkg::*;

	logic out_valid_q;

	assign empty    = !out_valid_q;
	assign rec_take = rec_valid && (!out_valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rec_take) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// The duration is only reported on the final beat of a file.
	always_ff @(posedge clk) begin
		if (rec_take) begin
			byte_out       <= rec.data_byte;
			kind           <= rec.kind;
			frame_mode     <= rec.frame_mode;
			frame_size     <= rec.frame_size;
			frame_time     <= rec.frame_time;
			skipped        <= rec.skipped;
			group_start    <= rec.group_start;
			last_out       <= rec.last;
			total_duration <= rec.last ? rec.sample_clock : 32'd0;
		end
	end

endmodule

// ----- hdl/amr_storage_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// amr_storage_frame_deframer - frame parser for AMR-NB storage files
// Walks the bytes of a storage file and tags each with its frame details.
// ----------------------------------------------------------------------------
// Usage. Bytes of the file enter one per beat on the input queue interface
// (push, full, data_byte, last); a beat is taken when push is high and full is
// low. Each input beat yields exactly one result beat on the output queue
// interface (empty, pop and the result fields), in order; a result is taken
// when pop is high and empty is low. The last flag ends a file: the parser
// forgets all per-file state and the next byte is read as the start of a new
// file, while the configuration registers keep their values.
// Timing. A byte is classified combinationally in the front part and written
// into the record queue at the edge that accepts it; the back part moves it
// into the output register once that register is empty or being popped, and
// from there it can be popped.
// One byte per cycle is sustained while results are popped and full is low;
// the front part updates its per-file state (frame byte counter, sample clock,
// group counter) once per byte.
// Stalls. When pop is held low the output register keeps its beat and the
// queue fills behind it; full rises once the queue is full and falls as soon
// as results drain again. Reset empties the queue and the output register and
// sets start_time to 0 and max_group to 10. The user must write registers via
// cfg_we, cfg_index and cfg_data only while no beat is in flight; unenforced.
// ----------------------------------------------------------------------------
module amr_storage_frame_deframer #(
	parameter int FRAME_SAMPLES = 160,
	parameter int QUEUE_DEPTH   = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration writes
	input  logic                             cfg_we,
	input  logic [amrd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [amrd_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input byte beats
	input  logic                             push,
	output logic                             full,
	input  logic [7:0]                       data_byte,
	input  logic                             last,
	// result beats
	output logic                             empty,
	input  logic                             pop,
	output logic [7:0]                       byte_out,
	output logic [1:0]                       kind,
	output logic [3:0]                       frame_mode,
	output logic [5:0]                       frame_size,
	output logic [31:0]                      frame_time,
	output logic                             skipped,
	output logic                             group_start,
	output logic                             last_out,
	output logic [31:0]                      total_duration
);
	import amrd_pkg::*;

	logic [31:0] start_time_q;
	logic [3:0]  max_group_q;

	logic        in_accept;
	rec_t        front_rec;
	rec_t        queue_rec;
	logic        queue_valid;
	logic        queue_take;

	// Configuration registers. An index outside the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q <= '0;
			max_group_q  <= MAX_GROUP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_TIME: start_time_q <= cfg_data;
				REG_MAX_GROUP:  max_group_q  <= cfg_data[3:0];
				default:        ;
			endcase
		end
	end

	assign in_accept = push && !full;

	// Front part: magic check, frame tracking and grouping, one byte per cycle while full is low.
	amrd_front #(
		.FRAME_SAMPLES(FRAME_SAMPLES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_accept),
		.data_byte  (data_byte),
		.last       (last),
		.start_time (start_time_q),
		.max_group  (max_group_q),
		.rec        (front_rec)
	);

	// Record queue: lets the input keep flowing while a result waits.
	amrd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (in_accept),
		.wr_data   (front_rec),
		.full      (full),
		.rd_en     (queue_take),
		.rd_data   (queue_rec),
		.not_empty (queue_valid)
	);

	// Back part: forms the result beat and holds it for the receiver.
	amrd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.rec_valid      (queue_valid),
		.rec            (queue_rec),
		.rec_take       (queue_take),
		.pop            (pop),
		.empty          (empty),
		.byte_out       (byte_out),
		.kind           (kind),
		.frame_mode     (frame_mode),
		.frame_size     (frame_size),
		.frame_time     (frame_time),
		.skipped        (skipped),
		.group_start    (group_start),
		.last_out       (last_out),
		.total_duration (total_duration)
	);

endmodule
